// File: sv/assert_macros.svh
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, quiet while reset is asserted (active low).
`define ASSERT_RST(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Clocked assertion that also holds during reset.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// File: sv/dabd_pkg.sv
package dabd_pkg;

  // Number of classes taking part in the argmax (1..4 with the fixed port layout).
  localparam int unsigned NumClasses = 4;

  // Field widths
  localparam int unsigned CoordW  = 16;
  localparam int unsigned SizeW   = 15;
  localparam int unsigned ScoreW  = 16;
  localparam int unsigned ClassW  = 2;
  localparam int unsigned EdgeW   = 15;
  localparam int unsigned OutSzW  = 14;
  localparam int unsigned InvW    = 24;
  localparam int unsigned PadW    = 10;
  localparam int unsigned OrigW   = 13;

  // Bus widths
  localparam int unsigned InDataW  = 128;
  localparam int unsigned OutDataW = 80;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 24;

  // Register indexes
  localparam logic [CfgIdxW-1:0] RegScoreThreshold = 3'd0;
  localparam logic [CfgIdxW-1:0] RegInverseScale   = 3'd1;
  localparam logic [CfgIdxW-1:0] RegPadLeft        = 3'd2;
  localparam logic [CfgIdxW-1:0] RegPadTop         = 3'd3;
  localparam logic [CfgIdxW-1:0] RegCropOriginX    = 3'd4;
  localparam logic [CfgIdxW-1:0] RegCropOriginY    = 3'd5;

  // Register reset values
  localparam logic [ScoreW-1:0] ThresholdRst = 16'd16384;
  localparam logic [InvW-1:0]   InvScaleRst  = 24'd65536;

  // Saturation limits
  localparam logic signed [21:0] EdgeMax = 22'sd16383;
  localparam logic signed [21:0] EdgeMin = -22'sd16384;
  localparam logic [18:0]        SizeMax = 19'd16383;

endpackage

// File: sv/detector_anchor_box_decode_top.sv
// Anchor box decoder. Each input word carries one detector anchor (center,
// size, four class scores); the block picks the best class (lowest index on a
// tie), drops the anchor if that score is below score_threshold, and otherwise
// maps the box from the letterboxed canvas back to source image pixels and
// sends one output word. Throughput is one word per clock while the output is
// not stalled: a four-stage pipeline (argmax and edge setup, magnitude,
// multiply by inverse_scale, truncate/offset/saturate into the output
// register) with a valid bit per stage. Stalls are absorbed stage by stage,
// so a stage holding a bubble keeps taking words. Dropped anchors leave
// bubbles, so the output stream is thinner than the input. Write the
// configuration registers only while the pipeline is empty.
module detector_anchor_box_decode_top (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // config write port
  input  logic                              cfg_we_i,
  input  logic [dabd_pkg::CfgIdxW-1:0]      cfg_index_i,
  input  logic [dabd_pkg::CfgDataW-1:0]     cfg_data_i,
  // anchor stream in
  input  logic                              s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  // center_x[15:0], center_y[31:16], box_w[46:32], box_h[61:47],
  // score_0[77:62], score_1[93:78], score_2[109:94], score_3[125:110], zero pad
  input  logic [dabd_pkg::InDataW-1:0]      s_axis_tdata_i,
  // box stream out
  output logic                              m_axis_tvalid_o,
  input  logic                              m_axis_tready_i,
  // out_x[14:0], out_y[29:15], out_width[43:30], out_height[57:44],
  // best_score[73:58], best_class[75:74], zero pad
  output logic [dabd_pkg::OutDataW-1:0]     m_axis_tdata_o
);

  // ---------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------
  logic [dabd_pkg::ScoreW-1:0] thr_q;
  logic [dabd_pkg::InvW-1:0]   inv_q;
  logic [dabd_pkg::PadW-1:0]   pad_l_q, pad_t_q;
  logic [dabd_pkg::OrigW-1:0]  orig_x_q, orig_y_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q    <= dabd_pkg::ThresholdRst;
      inv_q    <= dabd_pkg::InvScaleRst;
      pad_l_q  <= '0;
      pad_t_q  <= '0;
      orig_x_q <= '0;
      orig_y_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        dabd_pkg::RegScoreThreshold: thr_q    <= cfg_data_i[dabd_pkg::ScoreW-1:0];
        dabd_pkg::RegInverseScale:   inv_q    <= cfg_data_i[dabd_pkg::InvW-1:0];
        dabd_pkg::RegPadLeft:        pad_l_q  <= cfg_data_i[dabd_pkg::PadW-1:0];
        dabd_pkg::RegPadTop:         pad_t_q  <= cfg_data_i[dabd_pkg::PadW-1:0];
        dabd_pkg::RegCropOriginX:    orig_x_q <= cfg_data_i[dabd_pkg::OrigW-1:0];
        dabd_pkg::RegCropOriginY:    orig_y_q <= cfg_data_i[dabd_pkg::OrigW-1:0];
        default: ;  // unknown index: ignored
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Stall control: a stage loads when it is empty or its successor loads.
  // ---------------------------------------------------------------------
  logic v1_q, v2_q, v3_q, v4_q;
  logic rdy1, rdy2, rdy3, rdy4;

  assign rdy4 = !v4_q || m_axis_tready_i;
  assign rdy3 = !v3_q || rdy4;
  assign rdy2 = !v2_q || rdy3;
  assign rdy1 = !v1_q || rdy2;

  assign s_axis_tready_o = rdy1;

  // ---------------------------------------------------------------------
  // Stage 1: unpack, argmax, threshold, edge terms in Q.5
  // ---------------------------------------------------------------------
  logic signed [dabd_pkg::CoordW-1:0] cx, cy;
  logic [dabd_pkg::SizeW-1:0]         bw, bh;
  logic [dabd_pkg::ScoreW-1:0]        score [4];
  logic [dabd_pkg::ScoreW-1:0]        best_d;
  logic [dabd_pkg::ClassW-1:0]        cls_d;
  logic                               pass;
  logic signed [17:0]                 xs_d, ys_d;

  assign cx       = s_axis_tdata_i[15:0];
  assign cy       = s_axis_tdata_i[31:16];
  assign bw       = s_axis_tdata_i[46:32];
  assign bh       = s_axis_tdata_i[61:47];
  assign score[0] = s_axis_tdata_i[77:62];
  assign score[1] = s_axis_tdata_i[93:78];
  assign score[2] = s_axis_tdata_i[109:94];
  assign score[3] = s_axis_tdata_i[125:110];

  // strict compare keeps the lower class on a tie
  always_comb begin
    best_d = score[0];
    cls_d  = '0;
    for (int unsigned c = 1; c < dabd_pkg::NumClasses && c < 4; c++) begin
      if (score[c] > best_d) begin
        best_d = score[c];
        cls_d  = dabd_pkg::ClassW'(c);
      end
    end
  end

  assign pass = (best_d >= thr_q);

  // 2*c - size - 32*pad, exact in 18 bits
  assign xs_d = $signed({cx[dabd_pkg::CoordW-1], cx, 1'b0}) - $signed({3'b000, bw})
              - $signed({3'b000, pad_l_q, 5'b00000});
  assign ys_d = $signed({cy[dabd_pkg::CoordW-1], cy, 1'b0}) - $signed({3'b000, bh})
              - $signed({3'b000, pad_t_q, 5'b00000});

  logic [dabd_pkg::ScoreW-1:0] best1_q;
  logic [dabd_pkg::ClassW-1:0] cls1_q;
  logic signed [17:0]          xs1_q, ys1_q;
  logic [dabd_pkg::SizeW-1:0]  w1_q, h1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (rdy1) begin
      v1_q <= s_axis_tvalid_i && pass;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy1) begin
      best1_q <= best_d;
      cls1_q  <= cls_d;
      xs1_q   <= xs_d;
      ys1_q   <= ys_d;
      w1_q    <= bw;
      h1_q    <= bh;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 2: sign and magnitude of the edge terms
  // ---------------------------------------------------------------------
  logic signed [17:0] xs_neg, ys_neg;
  logic [16:0]        xmag_d, ymag_d;

  assign xs_neg = -xs1_q;
  assign ys_neg = -ys1_q;
  assign xmag_d = xs1_q[17] ? xs_neg[16:0] : xs1_q[16:0];
  assign ymag_d = ys1_q[17] ? ys_neg[16:0] : ys1_q[16:0];

  logic                        xn2_q, yn2_q;
  logic [16:0]                 xm2_q, ym2_q;
  logic [dabd_pkg::SizeW-1:0]  w2_q, h2_q;
  logic [dabd_pkg::ScoreW-1:0] best2_q;
  logic [dabd_pkg::ClassW-1:0] cls2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (rdy2) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy2) begin
      xn2_q   <= xs1_q[17];
      yn2_q   <= ys1_q[17];
      xm2_q   <= xmag_d;
      ym2_q   <= ymag_d;
      w2_q    <= w1_q;
      h2_q    <= h1_q;
      best2_q <= best1_q;
      cls2_q  <= cls1_q;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 3: four parallel multiplies by inverse_scale (17x24, 15x24)
  // ---------------------------------------------------------------------
  logic [40:0] px_d, py_d;
  logic [38:0] pw_d, ph_d;

  assign px_d = {24'd0, xm2_q} * {17'd0, inv_q};
  assign py_d = {24'd0, ym2_q} * {17'd0, inv_q};
  assign pw_d = {24'd0, w2_q}  * {15'd0, inv_q};
  assign ph_d = {24'd0, h2_q}  * {15'd0, inv_q};

  logic                        xn3_q, yn3_q;
  logic [40:0]                 px3_q, py3_q;
  logic [38:0]                 pw3_q, ph3_q;
  logic [dabd_pkg::ScoreW-1:0] best3_q;
  logic [dabd_pkg::ClassW-1:0] cls3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else if (rdy3) begin
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy3) begin
      xn3_q   <= xn2_q;
      yn3_q   <= yn2_q;
      px3_q   <= px_d;
      py3_q   <= py_d;
      pw3_q   <= pw_d;
      ph3_q   <= ph_d;
      best3_q <= best2_q;
      cls3_q  <= cls2_q;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 4: truncate toward zero, add crop origin, saturate
  // ---------------------------------------------------------------------
  logic [19:0]        qx, qy;
  logic signed [20:0] sx, sy;
  logic signed [21:0] ex, ey;
  logic [18:0]        qw, qh;
  logic [dabd_pkg::EdgeW-1:0]  ox_d, oy_d;
  logic [dabd_pkg::OutSzW-1:0] ow_d, oh_d;

  assign qx = px3_q[40:21];
  assign qy = py3_q[40:21];
  assign sx = xn3_q ? -$signed({1'b0, qx}) : $signed({1'b0, qx});
  assign sy = yn3_q ? -$signed({1'b0, qy}) : $signed({1'b0, qy});
  assign ex = $signed({sx[20], sx}) + $signed({9'd0, orig_x_q});
  assign ey = $signed({sy[20], sy}) + $signed({9'd0, orig_y_q});
  assign qw = pw3_q[38:20];
  assign qh = ph3_q[38:20];

  always_comb begin
    if (ex > dabd_pkg::EdgeMax)      ox_d = dabd_pkg::EdgeMax[dabd_pkg::EdgeW-1:0];
    else if (ex < dabd_pkg::EdgeMin) ox_d = dabd_pkg::EdgeMin[dabd_pkg::EdgeW-1:0];
    else                             ox_d = ex[dabd_pkg::EdgeW-1:0];
    if (ey > dabd_pkg::EdgeMax)      oy_d = dabd_pkg::EdgeMax[dabd_pkg::EdgeW-1:0];
    else if (ey < dabd_pkg::EdgeMin) oy_d = dabd_pkg::EdgeMin[dabd_pkg::EdgeW-1:0];
    else                             oy_d = ey[dabd_pkg::EdgeW-1:0];
    ow_d = (qw > dabd_pkg::SizeMax) ? dabd_pkg::SizeMax[dabd_pkg::OutSzW-1:0]
                                    : qw[dabd_pkg::OutSzW-1:0];
    oh_d = (qh > dabd_pkg::SizeMax) ? dabd_pkg::SizeMax[dabd_pkg::OutSzW-1:0]
                                    : qh[dabd_pkg::OutSzW-1:0];
  end

  logic [dabd_pkg::OutDataW-1:0] out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
    end else if (rdy4) begin
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy4) begin
      out_q <= {4'd0, cls3_q, best3_q, oh_d, ow_d, oy_d, ox_d};
    end
  end

  assign m_axis_tvalid_o = v4_q;
  assign m_axis_tdata_o  = out_q;

endmodule

// File: sv/dabd_checker.sv
`include "assert_macros.svh"

module dabd_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          s_axis_tvalid_i,
  input logic                          s_axis_tready_o,
  input logic                          m_axis_tvalid_o,
  input logic                          m_axis_tready_i,
  input logic [dabd_pkg::OutDataW-1:0] m_axis_tdata_o
);

  // a stalled output word holds
  `ASSERT_RST(a_out_hold, clk_i, rst_ni, m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o), "output word changed while stalled")

  // input back-pressure only when the output is full and stalled
  `ASSERT_RST(a_bp_cause, clk_i, rst_ni, !s_axis_tready_o |-> m_axis_tvalid_o && !m_axis_tready_i, "input stalled without output stall")

  // nothing leaves while in reset
  `ASSERT_ALWAYS(a_rst_quiet, clk_i, !rst_ni |-> !m_axis_tvalid_o, "output valid during reset")

endmodule

bind detector_anchor_box_decode_top dabd_checker u_dabd_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o)
);

// File: verif/tb_detector_anchor_box_decode_top.sv
`timescale 1ns / 1ps

// Anchors go in one word per accepted handshake. Each one is decoded here as
// well, and the box it should give, if any, is queued. Boxes coming out are
// checked field by field against the oldest queued box.
module tb_detector_anchor_box_decode_top;

  // Margin left after the last owed box before touching registers.
  localparam int SettleCycles = 8;
  localparam int DrainLimit   = 5000;
  localparam int RandPhases   = 6;
  localparam int PhaseWords   = 222;

  // Input word layout, lowest field last.
  typedef struct packed {
    logic [dabd_pkg::ScoreW-1:0] score_3;
    logic [dabd_pkg::ScoreW-1:0] score_2;
    logic [dabd_pkg::ScoreW-1:0] score_1;
    logic [dabd_pkg::ScoreW-1:0] score_0;
    logic [dabd_pkg::SizeW-1:0]  box_h;
    logic [dabd_pkg::SizeW-1:0]  box_w;
    logic [dabd_pkg::CoordW-1:0] center_y;
    logic [dabd_pkg::CoordW-1:0] center_x;
  } anchor_t;

  // Output word layout, lowest field last.
  typedef struct packed {
    logic [dabd_pkg::ClassW-1:0] best_class;
    logic [dabd_pkg::ScoreW-1:0] best_score;
    logic [dabd_pkg::OutSzW-1:0] out_height;
    logic [dabd_pkg::OutSzW-1:0] out_width;
    logic [dabd_pkg::EdgeW-1:0]  out_y;
    logic [dabd_pkg::EdgeW-1:0]  out_x;
  } box_t;

  // Keeps its own copy of the crop registers and the boxes still owed.
  class box_decode_checker;
    logic [dabd_pkg::ScoreW-1:0] thr;
    logic [dabd_pkg::InvW-1:0]   inv;
    logic [dabd_pkg::PadW-1:0]   pad_l;
    logic [dabd_pkg::PadW-1:0]   pad_t;
    logic [dabd_pkg::OrigW-1:0]  org_x;
    logic [dabd_pkg::OrigW-1:0]  org_y;
    box_t                        boxes_due[$];
    int                          fails;

    function new();
      thr   = dabd_pkg::ThresholdRst;
      inv   = dabd_pkg::InvScaleRst;
      pad_l = '0;
      pad_t = '0;
      org_x = '0;
      org_y = '0;
      fails = 0;
    endfunction

    function void set_reg(logic [dabd_pkg::CfgIdxW-1:0] idx,
                          logic [dabd_pkg::CfgDataW-1:0] val);
      case (idx)
        dabd_pkg::RegScoreThreshold: thr   = val[dabd_pkg::ScoreW-1:0];
        dabd_pkg::RegInverseScale:   inv   = val[dabd_pkg::InvW-1:0];
        dabd_pkg::RegPadLeft:        pad_l = val[dabd_pkg::PadW-1:0];
        dabd_pkg::RegPadTop:         pad_t = val[dabd_pkg::PadW-1:0];
        dabd_pkg::RegCropOriginX:    org_x = val[dabd_pkg::OrigW-1:0];
        dabd_pkg::RegCropOriginY:    org_y = val[dabd_pkg::OrigW-1:0];
        default: ;  // unused index: no register changes
      endcase
    endfunction

    // (v * k) >> sh, rounded toward zero
    static function longint scale_trunc(longint v, longint k, int sh);
      longint mag;
      mag = (v < 0) ? -v : v;
      mag = (mag * k) >>> sh;
      return (v < 0) ? -mag : mag;
    endfunction

    static function longint clip(longint v, longint lo, longint hi);
      return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    function bit decode_anchor(anchor_t a, output box_t b);
      logic [dabd_pkg::ScoreW-1:0] sc[4];
      logic [dabd_pkg::ScoreW-1:0] top;
      logic [dabd_pkg::ClassW-1:0] cls;
      longint xs, ys, ox, oy, ow, oh;
      sc[0] = a.score_0;
      sc[1] = a.score_1;
      sc[2] = a.score_2;
      sc[3] = a.score_3;
      top = sc[0];
      cls = '0;
      // strictly greater wins, so ties stay with the lower class
      for (int c = 1; c < dabd_pkg::NumClasses && c < 4; c++) begin
        if (sc[c] > top) begin
          top = sc[c];
          cls = dabd_pkg::ClassW'(c);
        end
      end
      b = '0;
      if (top < thr) return 1'b0;
      // edges in Q.5: 2*center - size - 32*pad
      xs = 2 * longint'($signed(a.center_x)) - longint'(a.box_w) - 32 * longint'(pad_l);
      ys = 2 * longint'($signed(a.center_y)) - longint'(a.box_h) - 32 * longint'(pad_t);
      ox = clip(scale_trunc(xs, longint'(inv), 21) + longint'(org_x),
                longint'(dabd_pkg::EdgeMin), longint'(dabd_pkg::EdgeMax));
      oy = clip(scale_trunc(ys, longint'(inv), 21) + longint'(org_y),
                longint'(dabd_pkg::EdgeMin), longint'(dabd_pkg::EdgeMax));
      ow = clip(scale_trunc(longint'(a.box_w), longint'(inv), 20), 0,
                longint'(dabd_pkg::SizeMax));
      oh = clip(scale_trunc(longint'(a.box_h), longint'(inv), 20), 0,
                longint'(dabd_pkg::SizeMax));
      b.out_x      = ox[dabd_pkg::EdgeW-1:0];
      b.out_y      = oy[dabd_pkg::EdgeW-1:0];
      b.out_width  = ow[dabd_pkg::OutSzW-1:0];
      b.out_height = oh[dabd_pkg::OutSzW-1:0];
      b.best_score = top;
      b.best_class = cls;
      return 1'b1;
    endfunction

    function void note_anchor(anchor_t a);
      box_t b;
      if (decode_anchor(a, b)) boxes_due.insert(boxes_due.size(), b);
    endfunction

    function int pending();
      return boxes_due.size();
    endfunction

    task report(string msg);
      $display("MISMATCH @%0t: %s", $realtime, msg);
      fails++;
    endtask

    task check_box(logic [dabd_pkg::OutDataW-1:0] d);
      box_t got;
      box_t want;
      got = box_t'(d[$bits(box_t)-1:0]);
      if (boxes_due.size() == 0) begin
        report($sformatf("box with nothing due: class %0d score %0d",
                         got.best_class, got.best_score));
        return;
      end
      want = boxes_due.pop_front();
      if (got.out_x !== want.out_x)
        report($sformatf("out_x got %0d want %0d", $signed(got.out_x), $signed(want.out_x)));
      if (got.out_y !== want.out_y)
        report($sformatf("out_y got %0d want %0d", $signed(got.out_y), $signed(want.out_y)));
      if (got.out_width !== want.out_width)
        report($sformatf("out_width got %0d want %0d", got.out_width, want.out_width));
      if (got.out_height !== want.out_height)
        report($sformatf("out_height got %0d want %0d", got.out_height, want.out_height));
      if (got.best_score !== want.best_score)
        report($sformatf("best_score got %0d want %0d", got.best_score, want.best_score));
      if (got.best_class !== want.best_class)
        report($sformatf("best_class got %0d want %0d", got.best_class, want.best_class));
    endtask

    task flush_report();
      if (boxes_due.size() != 0)
        report($sformatf("%0d boxes never came out", boxes_due.size()));
    endtask
  endclass

  // Block ports. Every input has a known value from time zero; reset goes
  // low right at time zero so the block sees a falling edge.
  logic                          clk     = 1'b0;
  logic                          rst_n   = 1'b1;
  logic                          cfg_we  = 1'b0;
  logic [dabd_pkg::CfgIdxW-1:0]  cfg_idx = '0;
  logic [dabd_pkg::CfgDataW-1:0] cfg_dat = '0;
  logic                          s_valid = 1'b0;
  logic                          s_ready;
  logic [dabd_pkg::InDataW-1:0]  s_data  = '0;
  logic                          m_valid;
  logic                          m_ready = 1'b0;
  logic [dabd_pkg::OutDataW-1:0] m_data;

  // No idling on either side while set.
  bit calm = 1'b0;

  box_decode_checker chk;

  detector_anchor_box_decode_top dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_we_i        (cfg_we),
    .cfg_index_i     (cfg_idx),
    .cfg_data_i      (cfg_dat),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Output side: values seen here are the ones from just before the edge,
  // so a box counts as taken when valid and ready were both high then.
  // Ready drops with a chance of 31 in a hundred unless calm.
  always @(posedge clk) begin
    if (m_valid && m_ready) chk.check_box(m_data);
    m_ready <= calm || ($urandom_range(0, 99) >= 31);
  end

  // One register write per clock; we stays high across a burst of writes
  // and the caller lowers it once, so it never drops and rises in one step.
  task automatic write_reg(logic [dabd_pkg::CfgIdxW-1:0] idx,
                           logic [dabd_pkg::CfgDataW-1:0] val);
    cfg_we  <= 1'b1;
    cfg_idx <= idx;
    cfg_dat <= val;
    @(posedge clk);
    chk.set_reg(idx, val);
  endtask

  // Load a whole crop setting; optionally hit the unused indexes too,
  // which the block should ignore.
  task automatic load_crop(int unsigned thr, int unsigned inv, int unsigned pl,
                           int unsigned pt, int unsigned ox, int unsigned oy,
                           bit poke_unused);
    write_reg(dabd_pkg::RegScoreThreshold, dabd_pkg::CfgDataW'(thr));
    write_reg(dabd_pkg::RegInverseScale, dabd_pkg::CfgDataW'(inv));
    write_reg(dabd_pkg::RegPadLeft, dabd_pkg::CfgDataW'(pl));
    write_reg(dabd_pkg::RegPadTop, dabd_pkg::CfgDataW'(pt));
    write_reg(dabd_pkg::RegCropOriginX, dabd_pkg::CfgDataW'(ox));
    write_reg(dabd_pkg::RegCropOriginY, dabd_pkg::CfgDataW'(oy));
    if (poke_unused) begin
      for (int i = int'(dabd_pkg::RegCropOriginY) + 1; i < 2 ** dabd_pkg::CfgIdxW; i++)
        write_reg(dabd_pkg::CfgIdxW'(i), dabd_pkg::CfgDataW'($urandom));
    end
    cfg_we <= 1'b0;
  endtask

  // Present one anchor and hold it until taken. Each cycle before it is
  // an idle one with a chance of 31 in a hundred unless calm.
  task automatic send_anchor(anchor_t a);
    while (!calm && $urandom_range(0, 99) < 31) begin
      s_valid <= 1'b0;
      @(posedge clk);
    end
    s_valid <= 1'b1;
    s_data  <= dabd_pkg::InDataW'(a);
    do @(posedge clk); while (!s_ready);
    chk.note_anchor(a);
  endtask

  // Stop sending and wait until every owed box is out, then let the
  // dropped anchors still in flight leave the pipe.
  task automatic wait_drained();
    int guard;
    guard = 0;
    s_valid <= 1'b0;
    while (chk.pending() != 0 && guard < DrainLimit) begin
      @(posedge clk);
      guard++;
    end
    repeat (SettleCycles) @(posedge clk);
  endtask

  function automatic anchor_t mk(int cx, int cy, int w, int h,
                                 int s0, int s1, int s2, int s3);
    anchor_t a;
    a.center_x = dabd_pkg::CoordW'(cx);
    a.center_y = dabd_pkg::CoordW'(cy);
    a.box_w    = dabd_pkg::SizeW'(w);
    a.box_h    = dabd_pkg::SizeW'(h);
    a.score_0  = dabd_pkg::ScoreW'(s0);
    a.score_1  = dabd_pkg::ScoreW'(s1);
    a.score_2  = dabd_pkg::ScoreW'(s2);
    a.score_3  = dabd_pkg::ScoreW'(s3);
    return a;
  endfunction

  // Mostly plausible boxes with random scores; some ties, some right at
  // the threshold, some with sizes anywhere in range.
  function automatic anchor_t random_anchor();
    anchor_t                     a;
    logic [dabd_pkg::ScoreW-1:0] peak;
    int                          pick;
    a.center_x = dabd_pkg::CoordW'($urandom);
    a.center_y = dabd_pkg::CoordW'($urandom);
    a.box_w    = dabd_pkg::SizeW'($urandom);
    a.box_h    = dabd_pkg::SizeW'($urandom);
    a.score_0  = dabd_pkg::ScoreW'($urandom);
    a.score_1  = dabd_pkg::ScoreW'($urandom);
    a.score_2  = dabd_pkg::ScoreW'($urandom);
    a.score_3  = dabd_pkg::ScoreW'($urandom);
    pick = $urandom_range(0, 9);
    if (pick < 6) begin
      a.box_w = dabd_pkg::SizeW'($urandom_range(0, 4095));
      a.box_h = dabd_pkg::SizeW'($urandom_range(0, 4095));
    end
    if (pick == 6) begin
      // best score within two of the threshold
      peak = chk.thr + dabd_pkg::ScoreW'($urandom_range(0, 4)) - dabd_pkg::ScoreW'(2);
      a.score_0 = dabd_pkg::ScoreW'($urandom_range(0, peak));
      a.score_1 = dabd_pkg::ScoreW'($urandom_range(0, peak));
      a.score_2 = dabd_pkg::ScoreW'($urandom_range(0, peak));
      a.score_3 = dabd_pkg::ScoreW'($urandom_range(0, peak));
      case ($urandom_range(0, 3))
        0: a.score_0 = peak;
        1: a.score_1 = peak;
        2: a.score_2 = peak;
        default: a.score_3 = peak;
      endcase
    end else if (pick >= 7) begin
      // some classes share one score
      peak = dabd_pkg::ScoreW'($urandom);
      if ($urandom_range(0, 1)) a.score_0 = peak;
      if ($urandom_range(0, 1)) a.score_1 = peak;
      if ($urandom_range(0, 1)) a.score_2 = peak;
      if ($urandom_range(0, 1)) a.score_3 = peak;
    end
    return a;
  endfunction

  initial begin
    int unsigned inv;
    rst_n <= 1'b0;
    chk = new();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings: threshold 0.25, unit scale, no pad, origin 0.
    send_anchor(mk(0, 0, 0, 0, 0, 0, 0, 0));                  // all zero: dropped
    send_anchor(mk(160, 320, 64, 32, 16384, 0, 0, 0));        // exactly at threshold
    send_anchor(mk(160, 320, 64, 32, 16383, 16383, 0, 0));    // one below
    send_anchor(mk(800, 96, 48, 80, 40000, 40000, 40000, 40000)); // full tie: class 0
    send_anchor(mk(33, 47, 5, 9, 20000, 50000, 50000, 50000));    // tie above class 0
    send_anchor(mk(-16, 16, 1, 3, 0, 0, 65535, 65534));       // class 2
    send_anchor(mk(4000, -4000, 200, 300, 1, 2, 3, 65535));   // class 3
    send_anchor(mk(-32768, 32767, 32767, 32767, 0, 0, 0, 65535));
    send_anchor(mk(32767, -32768, 0, 0, 65535, 0, 0, 0));
    send_anchor(mk(-1, -1, 1, 1, 30000, 0, 0, 0));            // tiny negative edge
    wait_drained();

    // Threshold zero, scale zero, widest pads and origins, unused indexes.
    load_crop(0, 0, 1023, 1023, 8191, 8191, 1'b1);
    send_anchor(mk(0, 0, 0, 0, 0, 0, 0, 0));                  // zero scores emit
    send_anchor(mk(32767, 32767, 32767, 32767, 7, 7, 9, 9));
    send_anchor(mk(-32768, -32768, 12, 0, 0, 1, 0, 0));
    wait_drained();

    // Highest threshold and scale: edges and sizes saturate.
    load_crop(65535, 24'hFFFFFF, 0, 0, 0, 0, 1'b0);
    send_anchor(mk(32767, 32767, 0, 32767, 0, 65535, 0, 0));
    send_anchor(mk(-32768, -32768, 32767, 0, 65535, 0, 0, 0));
    send_anchor(mk(100, 100, 10, 10, 65534, 65534, 65534, 65534)); // dropped
    send_anchor(mk(1, 1, 1, 1, 0, 0, 0, 65535));
    wait_drained();

    // Lowest nonzero threshold and scale, mixed pads and origins.
    load_crop(1, 1, 512, 0, 100, 4000, 1'b1);
    send_anchor(mk(0, 0, 100, 100, 1, 0, 0, 0));
    send_anchor(mk(0, 0, 100, 100, 0, 0, 0, 0));              // dropped
    send_anchor(mk(-5000, 7000, 32767, 32767, 0, 3, 3, 1));

    // Random crops. Phase 2 runs with no idling on either side; phase 1
    // stops once in the middle until every box is out.
    for (int p = 0; p < RandPhases; p++) begin
      wait_drained();
      calm = (p == 2);
      case ($urandom_range(0, 3))
        0: inv = $urandom_range(1, 24'hFFFFFF);
        1: inv = $urandom_range(1, 16383);
        2: inv = dabd_pkg::InvScaleRst;
        default: inv = $urandom_range(16384, 262144);
      endcase
      load_crop($urandom_range(0, 49152), inv, $urandom_range(0, 1023),
                $urandom_range(0, 1023), $urandom_range(0, 8191),
                $urandom_range(0, 8191), p == 4);
      for (int n = 0; n < PhaseWords; n++) begin
        if (p == 1 && n == PhaseWords / 2) wait_drained();
        send_anchor(random_anchor());
      end
    end
    calm = 1'b0;

    wait_drained();
    chk.flush_report();
    if (chk.fails == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Hard stop, far beyond the slowest legal run.
  initial begin
    #3000000;
    $display("Some tests failed");
    $finish;
  end

endmodule
